// ----- hdl/text_word_locator_top_assert.svh -----
// assertion macros of the text word locator, included by twl_fifo
`ifndef TEXT_WORD_LOCATOR_TOP_ASSERT_SVH
`define TEXT_WORD_LOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TWL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/twl_pkg.sv -----
// shared constants, types and helpers of the text word locator
package twl_pkg;

  // parameter defaults
  localparam int MAX_KEY_CHARS_DEF = 16;
  localparam int LABEL_CHARS_DEF   = 8;
  localparam int OFFSET_BITS_DEF   = 32;
  localparam int PAGE_BITS_DEF     = 16;

  // event queue depth (power of two)
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_LEN  = 2'd2;

  // word and counter limits
  localparam logic [7:0]  WORD_LEN_MAX = 8'd255;
  localparam logic [7:0]  MARKER_LEN   = 8'd7;
  localparam logic [15:0] MATCH_MAX    = 16'hFFFF;

  // character codes
  localparam logic [7:0] CH_DIGIT_LO = 8'd48;
  localparam logic [7:0] CH_DIGIT_HI = 8'd57;
  localparam logic [7:0] CH_UPPER_LO = 8'd65;
  localparam logic [7:0] CH_UPPER_HI = 8'd90;
  localparam logic [7:0] CH_LOWER_LO = 8'd97;
  localparam logic [7:0] CH_LOWER_HI = 8'd122;
  localparam logic [7:0] CH_DASH     = 8'd45;

  // what a word-end item asks of the back end
  typedef struct packed {
    logic       page_cand;
    logic       load_chapter;
    logic       key_hit;
    logic [3:0] chap_len;
  } evt_flags_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_UPPER_LO) && (c <= CH_UPPER_HI)) ||
           ((c >= CH_LOWER_LO) && (c <= CH_LOWER_HI)) || (c == CH_DASH);
  endfunction

  // characters of the chapter marker word
  function automatic logic [7:0] marker_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = "C";
      3'd1:    ch = "H";
      3'd2:    ch = "A";
      3'd3:    ch = "P";
      3'd4:    ch = "T";
      3'd5:    ch = "E";
      3'd6:    ch = "R";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/text_word_locator_top.sv -----
// top level of the text word locator
//
// Text bytes enter on in_valid_i / text_byte_i and are taken when in_stall_o
// is low. Letters, digits and '-' build a word; any other byte ends it. A
// word that matches the key gives one item on out_valid_o carrying the
// delimiter's byte offset, the page, the chapter label and a match index.
// Key registers are written over cfg_valid_i / cfg_index_i / cfg_data_i,
// always ready; the user must write them only while no bytes are in flight,
// as the block does not enforce it. Throughput: one byte per cycle while
// in_stall_o is low. A result reaches out_valid_o through the queue write,
// then the result register, later while earlier items wait. A four-entry
// word-end queue separates the front, which classifies bytes, from the
// back, which tracks page and chapter and holds the result register.
// When the receiver stalls, the result holds and further word ends fill the
// queue; once it is full in_stall_o rises until the back end drains it.
// Reset clears all control state at once: page 1, empty chapter, offset and
// match count zero, key length one. No clearing pass follows reset.
module text_word_locator_top #(
  parameter int MAX_KEY_CHARS = twl_pkg::MAX_KEY_CHARS_DEF,
  parameter int LABEL_CHARS   = twl_pkg::LABEL_CHARS_DEF,
  parameter int OFFSET_BITS   = twl_pkg::OFFSET_BITS_DEF,
  parameter int PAGE_BITS     = twl_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        text_byte_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [twl_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [63:0]                       cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [31:0]                       byte_offset_o,
  output logic [15:0]                       page_number_o,
  output logic [63:0]                       chapter_label_o,
  output logic [3:0]                        chapter_length_o,
  output logic [15:0]                       match_index_o
);

  localparam int PREFIX_W = LABEL_CHARS * 8;
  localparam int FLAGS_W  = $bits(twl_pkg::evt_flags_t);
  localparam int ENTRY_W  = FLAGS_W + PAGE_BITS + PREFIX_W + OFFSET_BITS;

  twl_pkg::evt_flags_t    front_flags, back_flags;
  logic [PAGE_BITS-1:0]   front_digit, back_digit;
  logic [PREFIX_W-1:0]    front_prefix, back_prefix;
  logic [OFFSET_BITS-1:0] front_offset, back_offset;
  logic [ENTRY_W-1:0]     q_wdata, q_rdata;
  logic                   q_push, q_pop, q_empty, q_full;

  // byte front end
  twl_front #(
    .MAX_KEY_CHARS (MAX_KEY_CHARS),
    .LABEL_CHARS   (LABEL_CHARS),
    .OFFSET_BITS   (OFFSET_BITS),
    .PAGE_BITS     (PAGE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .flags_o     (front_flags),
    .digit_o     (front_digit),
    .prefix_o    (front_prefix),
    .offset_o    (front_offset)
  );

  // word-end queue
  assign q_wdata = {front_flags, front_digit, front_prefix, front_offset};
  assign {back_flags, back_digit, back_prefix, back_offset} = q_rdata;

  twl_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // page, chapter and result back end
  twl_back #(
    .LABEL_CHARS (LABEL_CHARS),
    .OFFSET_BITS (OFFSET_BITS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_valid_i      (!q_empty),
    .flags_i          (back_flags),
    .digit_i          (back_digit),
    .prefix_i         (back_prefix),
    .offset_i         (back_offset),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_offset_o    (byte_offset_o),
    .page_number_o    (page_number_o),
    .chapter_label_o  (chapter_label_o),
    .chapter_length_o (chapter_length_o),
    .match_index_o    (match_index_o)
  );

endmodule

// ----- hdl/twl_front.sv -----
// front end: takes text bytes, tracks the current word and queues word-end items
module twl_front #(
  parameter int MAX_KEY_CHARS = twl_pkg::MAX_KEY_CHARS_DEF,
  parameter int LABEL_CHARS   = twl_pkg::LABEL_CHARS_DEF,
  parameter int OFFSET_BITS   = twl_pkg::OFFSET_BITS_DEF,
  parameter int PAGE_BITS     = twl_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        text_byte_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [twl_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [63:0]                       cfg_data_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output twl_pkg::evt_flags_t               flags_o,
  output logic [PAGE_BITS-1:0]              digit_o,
  output logic [LABEL_CHARS*8-1:0]          prefix_o,
  output logic [OFFSET_BITS-1:0]            offset_o
);

  localparam int PREFIX_W = LABEL_CHARS * 8;
  localparam int SUM_W    = PAGE_BITS + 4;
  localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;

  logic [63:0]            key_low_q, key_high_q;
  logic [4:0]             key_len_q;
  logic [7:0]             wlen_q, wlen_d;
  logic                   key_mis_q, key_mis_d;
  logic                   mark_mis_q, mark_mis_d;
  logic [PAGE_BITS-1:0]   digit_q, digit_d;
  logic                   not_page_q, not_page_d;
  logic [PREFIX_W-1:0]    prefix_q, prefix_d;
  logic                   after_mark_q, after_mark_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;

  logic                   accept;
  logic                   word;
  logic [127:0]           key_all;
  logic [7:0]             key_ch;
  logic [SUM_W-1:0]       digit_ext;
  logic [SUM_W-1:0]       sum;
  logic                   over;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        twl_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        twl_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        twl_pkg::CFG_KEY_LEN:  key_len_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // byte classification and per-character compares
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign word       = twl_pkg::is_word_char(text_byte_i);
  assign key_all    = {key_high_q, key_low_q};
  assign key_ch     = key_all[{wlen_q[3:0], 3'b000} +: 8];
  assign digit_ext  = SUM_W'(digit_q);
  assign sum        = (digit_ext << 3) + (digit_ext << 1) + SUM_W'(text_byte_i[3:0]);
  assign over       = sum > SUM_W'(PAGE_MAX);

  // word state update
  always_comb begin
    wlen_d       = wlen_q;
    key_mis_d    = key_mis_q;
    mark_mis_d   = mark_mis_q;
    digit_d      = digit_q;
    not_page_d   = not_page_q;
    prefix_d     = prefix_q;
    after_mark_d = after_mark_q;
    offset_d     = offset_q;
    if (accept) begin
      offset_d = offset_q + OFFSET_BITS'(1);
      if (word) begin
        key_mis_d = key_mis_q || (wlen_q >= 8'(MAX_KEY_CHARS)) || (key_ch != text_byte_i);
        mark_mis_d = mark_mis_q || (wlen_q >= twl_pkg::MARKER_LEN) ||
                     (twl_pkg::marker_char(wlen_q[2:0]) != text_byte_i);
        if (!twl_pkg::is_digit(text_byte_i) ||
            ((wlen_q == 8'd0) && (text_byte_i == twl_pkg::CH_DIGIT_LO))) begin
          not_page_d = 1'b1;
        end else if (!not_page_q) begin
          if (over) begin
            not_page_d = 1'b1;
          end else begin
            digit_d = sum[PAGE_BITS-1:0];
          end
        end
        for (int i = 0; i < LABEL_CHARS; i++) begin
          if (wlen_q == 8'(i)) begin
            prefix_d[i*8 +: 8] = text_byte_i;
          end
        end
        if (wlen_q != twl_pkg::WORD_LEN_MAX) begin
          wlen_d = wlen_q + 8'd1;
        end
      end else begin
        after_mark_d = !mark_mis_q && (wlen_q == twl_pkg::MARKER_LEN);
        wlen_d       = '0;
        key_mis_d    = 1'b0;
        mark_mis_d   = 1'b0;
        digit_d      = '0;
        not_page_d   = 1'b0;
        prefix_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q       <= '0;
      key_mis_q    <= 1'b0;
      mark_mis_q   <= 1'b0;
      digit_q      <= '0;
      not_page_q   <= 1'b0;
      prefix_q     <= '0;
      after_mark_q <= 1'b0;
      offset_q     <= '0;
    end else begin
      wlen_q       <= wlen_d;
      key_mis_q    <= key_mis_d;
      mark_mis_q   <= mark_mis_d;
      digit_q      <= digit_d;
      not_page_q   <= not_page_d;
      prefix_q     <= prefix_d;
      after_mark_q <= after_mark_d;
      offset_q     <= offset_d;
    end
  end

  // word-end item, queued only when it touches page, chapter or result
  always_comb begin
    flags_o.page_cand    = (wlen_q != 8'd0) && !not_page_q;
    flags_o.load_chapter = after_mark_q;
    flags_o.key_hit      = (key_len_q != 5'd0) && (key_len_q <= 5'(MAX_KEY_CHARS)) &&
                           !key_mis_q && (wlen_q == 8'(key_len_q));
    flags_o.chap_len     = (wlen_q < 8'(LABEL_CHARS)) ? wlen_q[3:0] : 4'(LABEL_CHARS);
  end

  assign push_o   = accept && !word &&
                    (flags_o.page_cand || flags_o.load_chapter || flags_o.key_hit);
  assign digit_o  = digit_q;
  assign prefix_o = prefix_q;
  assign offset_o = offset_q;

endmodule

// ----- hdl/twl_fifo.sv -----
// short item queue between front and back end
`include "text_word_locator_top_assert.svh"

module twl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int DEPTH = twl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  // storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));

  // queue sanity
  `TWL_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "queue count out of range")
  `TWL_ASSERT_NOW(a_no_overflow, push_i, !full_o || pop_i, "item pushed into full queue")
  `TWL_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "item popped from empty queue")
  `TWL_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + CNT_W'(1),
                   "queue count did not advance on push")

endmodule

// ----- hdl/twl_back.sv -----
// back end: page and chapter tracking, match counting and the result register
module twl_back #(
  parameter int LABEL_CHARS = twl_pkg::LABEL_CHARS_DEF,
  parameter int OFFSET_BITS = twl_pkg::OFFSET_BITS_DEF,
  parameter int PAGE_BITS   = twl_pkg::PAGE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       evt_valid_i,
  input  twl_pkg::evt_flags_t        flags_i,
  input  logic [PAGE_BITS-1:0]       digit_i,
  input  logic [LABEL_CHARS*8-1:0]   prefix_i,
  input  logic [OFFSET_BITS-1:0]     offset_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                byte_offset_o,
  output logic [15:0]                page_number_o,
  output logic [63:0]                chapter_label_o,
  output logic [3:0]                 chapter_length_o,
  output logic [15:0]                match_index_o
);

  localparam int PREFIX_W = LABEL_CHARS * 8;
  localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;

  logic [PAGE_BITS-1:0] page_q, page_next;
  logic [PREFIX_W-1:0]  chap_q, chap_next;
  logic [3:0]           chap_len_q, chap_len_next;
  logic [15:0]          matches_q;
  logic                 out_valid_q;

  // page advance and chapter label after this item
  assign page_next = (flags_i.page_cand && (digit_i == page_q) && (page_q != PAGE_MAX)) ?
                     page_q + PAGE_BITS'(1) : page_q;
  assign chap_next     = flags_i.load_chapter ? prefix_i : chap_q;
  assign chap_len_next = flags_i.load_chapter ? flags_i.chap_len : chap_len_q;

  // a hit waits only while the result register is held
  assign pop_o = evt_valid_i && (!flags_i.key_hit || !out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q      <= PAGE_BITS'(1);
      chap_q      <= '0;
      chap_len_q  <= '0;
      matches_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        page_q     <= page_next;
        chap_q     <= chap_next;
        chap_len_q <= chap_len_next;
        if (flags_i.key_hit && (matches_q != twl_pkg::MATCH_MAX)) begin
          matches_q <= matches_q + 16'd1;
        end
      end
      if (pop_o && flags_i.key_hit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && flags_i.key_hit) begin
      byte_offset_o    <= 32'(offset_i);
      page_number_o    <= 16'(page_next);
      chapter_label_o  <= 64'(chap_next);
      chapter_length_o <= chap_len_next;
      match_index_o    <= matches_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
